// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define DBR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication
`define DBR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/dbr_pkg.sv =====
// ---------------------------------------------------------------------------
// dbr_pkg
// Types, codes and helpers for the DMA double-buffer descriptor ring.
// ---------------------------------------------------------------------------
package dbr_pkg;

	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 18;
	localparam int XFR_W   = 16;
	localparam int QCNT_W  = 4;
	localparam int STAT_W  = 2;
	localparam int ACT_W   = 3;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 2;

	// Request codes
	typedef enum logic [2:0] {
		REQ_APPEND  = 3'd0,
		REQ_ENABLE  = 3'd1,
		REQ_DONE    = 3'd2,
		REQ_ERROR   = 3'd3,
		REQ_DISABLE = 3'd4,
		REQ_CLEAR   = 3'd5,
		REQ_STATUS  = 3'd6,
		REQ_RESIDUE = 3'd7
	} req_e;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BUSY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ERR  = 2'd2;

	// Stream actions
	localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLR_EN   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SHUTDOWN = 3'd3;
	localparam logic [ACT_W-1:0] ACT_MASK     = 3'd4;

	// Configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		CFG_DIRECTION = 2'd0,
		CFG_PERIPH_W  = 2'd1,
		CFG_MEM_W     = 2'd2
	} cfg_idx_e;

	// Stream states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READY = 5'b00010,
		ST_DONE  = 5'b00100,
		ST_BUSY  = 5'b01000,
		ST_ERROR = 5'b10000
	} state_e;

	typedef struct packed {
		logic       direction;
		logic [1:0] periph_w;
		logic [1:0] mem_w;
	} cfg_t;

	// Decoded result of one request, waiting for the ring read data
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [QCNT_W-1:0] queued_count;
		logic [SIZE_W-1:0] residue_bytes;
		logic              first_write;
		logic              first_from_a;
		logic              second_write;
		logic              second_from_a;
		logic              second_from_b;
		logic [ADDR_W-1:0] periph_addr;
		logic [XFR_W-1:0]  transfer_count;
		logic [ACT_W-1:0]  stream_action;
		logic              double_buffer;
		logic              notify;
	} res_t;

	// Complete result word
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [QCNT_W-1:0] queued_count;
		logic [SIZE_W-1:0] residue_bytes;
		logic              first_ptr_write;
		logic [ADDR_W-1:0] first_ptr_addr;
		logic              second_ptr_write;
		logic [ADDR_W-1:0] second_ptr_addr;
		logic [ADDR_W-1:0] periph_addr_out;
		logic [XFR_W-1:0]  transfer_count;
		logic [ACT_W-1:0]  stream_action;
		logic              double_buffer;
		logic              notify;
	} out_t;

	// Width codes above two count as two
	function automatic logic [1:0] clamp_w(input logic [1:0] w);
		return (w > 2'd2) ? 2'd2 : w;
	endfunction

endpackage

// ===== rtl/dbr_if.sv =====
// ---------------------------------------------------------------------------
// dbr_if
// Valid/ready channels for requests, results and configuration writes.
// ---------------------------------------------------------------------------
interface dbr_req_if;
	logic                         valid;
	logic                         ready;
	logic [2:0]                   req_type;
	logic [dbr_pkg::ADDR_W-1:0]   source_addr;
	logic [dbr_pkg::ADDR_W-1:0]   dest_addr;
	logic [dbr_pkg::SIZE_W-1:0]   size_bytes;
	logic                         current_target;
	logic [dbr_pkg::XFR_W-1:0]    remaining_count;

	modport source(output valid, req_type, source_addr, dest_addr, size_bytes,
		current_target, remaining_count, input ready);
	modport sink(input valid, req_type, source_addr, dest_addr, size_bytes,
		current_target, remaining_count, output ready);
endinterface

interface dbr_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [dbr_pkg::STAT_W-1:0]   status;
	logic [dbr_pkg::QCNT_W-1:0]   queued_count;
	logic [dbr_pkg::SIZE_W-1:0]   residue_bytes;
	logic                         first_ptr_write;
	logic [dbr_pkg::ADDR_W-1:0]   first_ptr_addr;
	logic                         second_ptr_write;
	logic [dbr_pkg::ADDR_W-1:0]   second_ptr_addr;
	logic [dbr_pkg::ADDR_W-1:0]   periph_addr_out;
	logic [dbr_pkg::XFR_W-1:0]    transfer_count;
	logic [dbr_pkg::ACT_W-1:0]    stream_action;
	logic                         double_buffer;
	logic                         notify;

	modport source(output valid, status, queued_count, residue_bytes,
		first_ptr_write, first_ptr_addr, second_ptr_write, second_ptr_addr,
		periph_addr_out, transfer_count, stream_action, double_buffer, notify,
		input ready);
	modport sink(input valid, status, queued_count, residue_bytes,
		first_ptr_write, first_ptr_addr, second_ptr_write, second_ptr_addr,
		periph_addr_out, transfer_count, stream_action, double_buffer, notify,
		output ready);
endinterface

interface dbr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dbr_pkg::CIDX_W-1:0]    index;
	logic [dbr_pkg::CDATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/dma_double_buffer_descriptor_ring.sv =====
// A result is registered in the first result stage, then in the result register.
// Throughput: one request per cycle unless both stages are full and the result is not taken;
// the state update, ring write and ring read data land at the accept edge, the result register follows.
// Reset clears the state machine, count, write index and saved start values;
// the ring memory is not cleared and an entry reads as written.
// ---------------------------------------------------------------------------
// dma_double_buffer_descriptor_ring
// Descriptor ring and stream control for a double-buffered DMA channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dma_double_buffer_descriptor_ring #(
	parameter int CAPACITY = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	dbr_cfg_if.sink    cfg,
	dbr_req_if.sink    req,
	dbr_rsp_if.source  rsp
);

	dbr_pkg::cfg_t               cfg_q;
	dbr_pkg::res_t               res_s1;
	logic                        s1_v;
	logic                        adv;
	logic [dbr_pkg::ADDR_W-1:0]  rd_a_s1;
	logic [dbr_pkg::ADDR_W-1:0]  rd_b_s1;

	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (dbr_pkg::cfg_idx_e'(cfg.index))
				dbr_pkg::CFG_DIRECTION: cfg_q.direction <= cfg.data[0];
				dbr_pkg::CFG_PERIPH_W:  cfg_q.periph_w  <= cfg.data;
				dbr_pkg::CFG_MEM_W:     cfg_q.mem_w     <= cfg.data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	dbr_ring #(
		.CAPACITY(CAPACITY)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cfg     (cfg_q),
		.adv     (adv),
		.s1_v    (s1_v),
		.res_s1  (res_s1),
		.rd_a_s1 (rd_a_s1),
		.rd_b_s1 (rd_b_s1)
	);

	dbr_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1_v    (s1_v),
		.res_s1  (res_s1),
		.rd_a_s1 (rd_a_s1),
		.rd_b_s1 (rd_b_s1),
		.adv     (adv),
		.rsp     (rsp)
	);

	// Stall reaches the input when both stages are full and the result is not taken
	`DBR_ASSERT_SAME(a_stall_input, s1_v && rsp.valid && !rsp.ready, !req.ready)
	// A taken result with nothing behind it leaves the output empty
	`DBR_ASSERT_NEXT(a_no_phantom, rsp.valid && rsp.ready && !s1_v, !rsp.valid)
	// The first pointer loads only on a start or a completion
	`DBR_ASSERT_SAME(a_first_ptr_src, rsp.valid && rsp.first_ptr_write, rsp.stream_action == dbr_pkg::ACT_START || rsp.notify)
	// A completion never starts or masks the stream
	`DBR_ASSERT_SAME(a_notify_action, rsp.valid && rsp.notify, rsp.stream_action != dbr_pkg::ACT_START && rsp.stream_action != dbr_pkg::ACT_MASK)

endmodule

// ===== rtl/dbr_ring.sv =====
// ---------------------------------------------------------------------------
// dbr_ring
// Stream state machine, ring memory and first result stage.
// ---------------------------------------------------------------------------
module dbr_ring #(
	parameter int CAPACITY = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dbr_req_if.sink                      req,
	input  dbr_pkg::cfg_t                cfg,
	input  logic                         adv,
	output logic                         s1_v,
	output dbr_pkg::res_t                res_s1,
	output logic [dbr_pkg::ADDR_W-1:0]   rd_a_s1,
	output logic [dbr_pkg::ADDR_W-1:0]   rd_b_s1
);

	localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);

	logic [dbr_pkg::ADDR_W-1:0] ring_mem [CAPACITY];

	logic [IDX_W-1:0]          wi_q, wi_n, wi_b;
	logic [CNT_W-1:0]          pend_q, pend_n, pend_b, pend_dec;
	dbr_pkg::state_e           st_q, st_n;
	logic [dbr_pkg::ADDR_W-1:0] per_q, per_n;
	logic [dbr_pkg::XFR_W-1:0]  xfr_q, xfr_n;

	logic                      accept;
	logic [1:0]                aw;
	logic [dbr_pkg::SIZE_W-1:0] shifted;
	logic [dbr_pkg::XFR_W-1:0]  xfers;
	logic [IDX_W:0]            idx_sum;
	logic [IDX_W-1:0]          idx;
	logic [IDX_W-1:0]          rd_addr;
	logic                      wr_en;
	logic [dbr_pkg::ADDR_W-1:0] mem_addr;
	logic [dbr_pkg::ADDR_W-1:0] per_addr;
	logic [31:0]               pend_w;
	dbr_pkg::res_t             res;

	assign req.ready = !s1_v || adv;
	assign accept    = req.valid && req.ready;

	// Element size, route and transfer count
	assign aw       = cfg.direction ? dbr_pkg::clamp_w(cfg.periph_w)
	                                : dbr_pkg::clamp_w(cfg.mem_w);
	assign mem_addr = cfg.direction ? req.source_addr : req.dest_addr;
	assign per_addr = cfg.direction ? req.dest_addr : req.source_addr;
	assign shifted  = req.size_bytes >> aw;
	assign xfers    = (|shifted[dbr_pkg::SIZE_W-1:dbr_pkg::XFR_W]) ? '1
	                                                              : shifted[dbr_pkg::XFR_W-1:0];

	// Oldest pending entry after a completion
	assign pend_dec = (pend_q == '0) ? '0 : pend_q - 1'b1;
	assign idx_sum  = {1'b0, wi_q} + CAP_SUM - (IDX_W + 1)'(pend_dec);
	assign idx      = (idx_sum >= CAP_SUM) ? IDX_W'(idx_sum - CAP_SUM) : idx_sum[IDX_W-1:0];

	// Decode the request against the current state
	always_comb begin
		wi_n    = wi_q;
		pend_n  = pend_q;
		st_n    = st_q;
		per_n   = per_q;
		xfr_n   = xfr_q;
		res     = '0;
		wr_en   = 1'b0;
		rd_addr = idx;
		wi_b    = (st_q == dbr_pkg::ST_READY || st_q == dbr_pkg::ST_BUSY) ? wi_q : '0;
		pend_b  = (st_q == dbr_pkg::ST_READY || st_q == dbr_pkg::ST_BUSY) ? pend_q : '0;
		unique case (dbr_pkg::req_e'(req.req_type))
			dbr_pkg::REQ_APPEND: begin
				wi_n   = wi_b;
				pend_n = pend_b;
				if (pend_b == CAP_CNT) begin
					res.status = dbr_pkg::STAT_ERR;
				end else begin
					wr_en  = 1'b1;
					wi_n   = (wi_b == LAST_IDX) ? '0 : wi_b + 1'b1;
					pend_n = pend_b + 1'b1;
					if (st_q != dbr_pkg::ST_BUSY) begin
						per_n = per_addr;
						xfr_n = xfers;
						st_n  = dbr_pkg::ST_READY;
					end
				end
			end
			dbr_pkg::REQ_ENABLE: begin
				rd_addr = '0;
				if (st_q != dbr_pkg::ST_READY) begin
					res.status = dbr_pkg::STAT_ERR;
				end else begin
					st_n               = dbr_pkg::ST_BUSY;
					res.first_write    = 1'b1;
					res.first_from_a   = 1'b1;
					res.second_write   = 1'b1;
					res.second_from_b  = (pend_q > CNT_W'(1));
					res.double_buffer  = (pend_q > CNT_W'(1));
					res.periph_addr    = per_q;
					res.transfer_count = xfr_q;
					res.stream_action  = dbr_pkg::ACT_START;
				end
			end
			dbr_pkg::REQ_DONE, dbr_pkg::REQ_ERROR: begin
				if (st_q == dbr_pkg::ST_BUSY) begin
					pend_n = pend_dec;
					if (req.req_type == dbr_pkg::REQ_DONE) begin
						if (pend_dec != '0) begin
							if (req.current_target) begin
								res.first_write  = 1'b1;
								res.first_from_a = 1'b1;
							end else begin
								res.second_write  = 1'b1;
								res.second_from_a = 1'b1;
							end
							if (pend_dec == CNT_W'(1)) begin
								res.stream_action = dbr_pkg::ACT_CLR_EN;
							end
						end else begin
							st_n = dbr_pkg::ST_IDLE;
						end
					end else begin
						st_n = dbr_pkg::ST_ERROR;
					end
					if (st_n != dbr_pkg::ST_BUSY) begin
						res.stream_action = dbr_pkg::ACT_SHUTDOWN;
					end
					res.notify = 1'b1;
				end
			end
			dbr_pkg::REQ_DISABLE: begin
				if (st_q == dbr_pkg::ST_BUSY) begin
					res.stream_action = dbr_pkg::ACT_MASK;
					st_n              = dbr_pkg::ST_DONE;
				end
			end
			dbr_pkg::REQ_CLEAR: begin
				wi_n   = '0;
				pend_n = '0;
				st_n   = dbr_pkg::ST_IDLE;
			end
			dbr_pkg::REQ_STATUS: begin
				if (st_q == dbr_pkg::ST_BUSY) begin
					res.status = dbr_pkg::STAT_BUSY;
				end else if (st_q == dbr_pkg::ST_ERROR) begin
					res.status = dbr_pkg::STAT_ERR;
				end
			end
			dbr_pkg::REQ_RESIDUE: begin
				if (st_q != dbr_pkg::ST_IDLE && st_q != dbr_pkg::ST_READY) begin
					res.residue_bytes = dbr_pkg::SIZE_W'(req.remaining_count) << aw;
				end else begin
					res.status = dbr_pkg::STAT_ERR;
				end
			end
		endcase
		pend_w           = 32'(pend_n);
		res.queued_count = (st_n != dbr_pkg::ST_IDLE) ? pend_w[dbr_pkg::QCNT_W-1:0] : '0;
	end

	// Advance the ring state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q   <= '0;
			pend_q <= '0;
			st_q   <= dbr_pkg::ST_IDLE;
			per_q  <= '0;
			xfr_q  <= '0;
		end else if (accept) begin
			wi_q   <= wi_n;
			pend_q <= pend_n;
			st_q   <= st_n;
			per_q  <= per_n;
			xfr_q  <= xfr_n;
		end
	end

	// Hold the stage valid until the output stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (accept) begin
			s1_v <= 1'b1;
		end else if (adv) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// Ring memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			ring_mem[wi_b] <= mem_addr;
		end
		if (accept) begin
			rd_a_s1 <= ring_mem[rd_addr];
			rd_b_s1 <= ring_mem[IDX_W'(1)];
		end
	end

endmodule

// ===== rtl/dbr_out.sv =====
// ---------------------------------------------------------------------------
// dbr_out
// Result register: merges ring read data into the decoded result.
// ---------------------------------------------------------------------------
module dbr_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s1_v,
	input  dbr_pkg::res_t                res_s1,
	input  logic [dbr_pkg::ADDR_W-1:0]   rd_a_s1,
	input  logic [dbr_pkg::ADDR_W-1:0]   rd_b_s1,
	output logic                         adv,
	dbr_rsp_if.source                    rsp
);

	logic          v_s2;
	dbr_pkg::out_t out_s2;
	dbr_pkg::out_t out_n;

	assign adv = !v_s2 || rsp.ready;

	// Pick pointer addresses from the ring read ports
	always_comb begin
		out_n.status           = res_s1.status;
		out_n.queued_count     = res_s1.queued_count;
		out_n.residue_bytes    = res_s1.residue_bytes;
		out_n.first_ptr_write  = res_s1.first_write;
		out_n.first_ptr_addr   = res_s1.first_from_a ? rd_a_s1 : '0;
		out_n.second_ptr_write = res_s1.second_write;
		out_n.second_ptr_addr  = res_s1.second_from_a ? rd_a_s1 :
		                         res_s1.second_from_b ? rd_b_s1 : '0;
		out_n.periph_addr_out  = res_s1.periph_addr;
		out_n.transfer_count   = res_s1.transfer_count;
		out_n.stream_action    = res_s1.stream_action;
		out_n.double_buffer    = res_s1.double_buffer;
		out_n.notify           = res_s1.notify;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_v) begin
			out_s2 <= out_n;
		end
	end

	assign rsp.valid            = v_s2;
	assign rsp.status           = out_s2.status;
	assign rsp.queued_count     = out_s2.queued_count;
	assign rsp.residue_bytes    = out_s2.residue_bytes;
	assign rsp.first_ptr_write  = out_s2.first_ptr_write;
	assign rsp.first_ptr_addr   = out_s2.first_ptr_addr;
	assign rsp.second_ptr_write = out_s2.second_ptr_write;
	assign rsp.second_ptr_addr  = out_s2.second_ptr_addr;
	assign rsp.periph_addr_out  = out_s2.periph_addr_out;
	assign rsp.transfer_count   = out_s2.transfer_count;
	assign rsp.stream_action    = out_s2.stream_action;
	assign rsp.double_buffer    = out_s2.double_buffer;
	assign rsp.notify           = out_s2.notify;

endmodule
